/* rtl/xcfd_pkg.sv */
// Package for the XOR-checked frame deframer.
// Holds register indexes, reset values, result kinds and the shared structs.
// No dependencies.
package xcfd_pkg;

    // Fixed widths of the item and result fields
    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 16;
    localparam int FLEN_W    = 17;
    localparam int BCOUNT_W  = 8;

    // Default burst size in received bytes
    localparam int BURST_BYTES_DEF = 128;

    // Configuration register indexes and reset values
    localparam logic REG_HDR_FIRST  = 1'b0;
    localparam logic REG_HDR_SECOND = 1'b1;
    localparam logic [BYTE_W-1:0] HDR_FIRST_RST  = 8'hA5;
    localparam logic [BYTE_W-1:0] HDR_SECOND_RST = 8'h5A;

    // Input item codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_IDLE = 1'b1;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_COMMIT = 2'd1,
        KIND_DROP   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_HUNT1,
        PH_HUNT2,
        PH_LENHI,
        PH_LENLO,
        PH_BODY,
        PH_IGNORE
    } phase_t;

    typedef struct packed {
        kind_t              kind;
        logic [BYTE_W-1:0]  frame_byte;
        logic [FLEN_W-1:0]  frame_length;
        logic               last;
    } result_t;

    // Up to two results produced by one request
    typedef struct packed {
        logic [1:0] cnt;
        result_t    res0;
        result_t    res1;
    } push_t;

    function automatic result_t make_result(kind_t k, logic [BYTE_W-1:0] b,
                                            logic [FLEN_W-1:0] len);
        result_t r;
        r.kind         = k;
        r.frame_byte   = b;
        r.frame_length = len;
        r.last         = 1'b0;
        return r;
    endfunction

endpackage

/* rtl/xcfd_item_if.sv */
// Input channel of the deframer: received bytes and line-idle events.
// Depends on nothing.
interface xcfd_item_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

/* rtl/xcfd_result_if.sv */
// Output channel of the deframer: tentative bytes, commits and drops.
// Depends on nothing.
interface xcfd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  frame_byte;
    logic [16:0] frame_length;
    logic        last;

    modport source (output valid, output kind, output frame_byte,
                    output frame_length, output last, input ready);
    modport sink   (input valid, input kind, input frame_byte,
                    input frame_length, input last, output ready);
endinterface

/* rtl/xcfd_core.sv */
// Deframer state machine: header hunt, length capture, XOR check, burst count.
// Produces up to two results per accepted request. Depends on xcfd_pkg.
module xcfd_core
    import xcfd_pkg::*;
#(
    parameter int BURST_BYTES = BURST_BYTES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  logic                op,
    input  logic [BYTE_W-1:0]   rx_byte,
    input  logic [BYTE_W-1:0]   hdr_first,
    input  logic [BYTE_W-1:0]   hdr_second,
    output push_t               push
);

    localparam logic [BCOUNT_W-1:0] BURST_LIMIT = BCOUNT_W'(BURST_BYTES);

    phase_t              phase_reg, phase_next;
    logic [LEN_W-1:0]    len_reg, len_next;
    logic [LEN_W-1:0]    remain_reg, remain_next;
    logic [BYTE_W-1:0]   xor_reg, xor_next;
    logic [BCOUNT_W-1:0] bcount_reg, bcount_next;

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT1;
            len_reg    <= '0;
            remain_reg <= '0;
            xor_reg    <= '0;
            bcount_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            len_reg    <= len_next;
            remain_reg <= remain_next;
            xor_reg    <= xor_next;
            bcount_reg <= bcount_next;
        end
    end

    // Next state and results for the request at the port
    always_comb
    begin
        logic                burst_end;
        logic [BCOUNT_W-1:0] bcount_inc;
        logic [LEN_W-1:0]    len_tmp;
        result_t             res [2];
        logic [1:0]          cnt;

        phase_next  = phase_reg;
        len_next    = len_reg;
        remain_next = remain_reg;
        xor_next    = xor_reg;
        bcount_inc  = bcount_reg + BCOUNT_W'(1);
        len_tmp     = '0;
        cnt         = 2'd0;
        res[0]      = make_result(KIND_BYTE, '0, '0);
        res[1]      = make_result(KIND_BYTE, '0, '0);

        if (op == OP_IDLE)
        begin
            burst_end   = 1'b1;
            bcount_next = '0;
        end
        else
        begin
            burst_end   = (bcount_inc >= BURST_LIMIT);
            bcount_next = burst_end ? '0 : bcount_inc;

            unique case (phase_reg)
                PH_HUNT2:
                begin
                    if (rx_byte == hdr_second)
                    begin
                        if (burst_end)
                        begin
                            phase_next = PH_HUNT1;
                        end
                        else
                        begin
                            res[0]     = make_result(KIND_BYTE, hdr_first, '0);
                            res[1]     = make_result(KIND_BYTE, hdr_second, '0);
                            cnt        = 2'd2;
                            xor_next   = hdr_first ^ hdr_second;
                            phase_next = PH_LENHI;
                        end
                    end
                    else if (rx_byte != hdr_first)
                    begin
                        phase_next = PH_HUNT1;
                    end
                end
                PH_LENHI:
                begin
                    res[0]     = make_result(KIND_BYTE, rx_byte, '0);
                    cnt        = 2'd1;
                    len_next   = {rx_byte, {BYTE_W{1'b0}}};
                    xor_next   = xor_reg ^ rx_byte;
                    phase_next = PH_LENLO;
                end
                PH_LENLO:
                begin
                    res[0]   = make_result(KIND_BYTE, rx_byte, '0);
                    cnt      = 2'd1;
                    len_tmp  = {len_reg[LEN_W-1:BYTE_W], rx_byte};
                    len_next = len_tmp;
                    xor_next = xor_reg ^ rx_byte;
                    if (len_tmp == '0)
                    begin
                        res[1]     = make_result(KIND_DROP, '0, '0);
                        cnt        = 2'd2;
                        phase_next = PH_IGNORE;
                    end
                    else
                    begin
                        remain_next = len_tmp;
                        phase_next  = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    cnt = 2'd1;
                    if (remain_reg <= LEN_W'(1))
                    begin
                        remain_next = '0;
                        if (rx_byte == xor_reg)
                        begin
                            res[0]     = make_result(KIND_COMMIT, '0,
                                                     {1'b0, len_reg} + FLEN_W'(3));
                            phase_next = PH_HUNT1;
                        end
                        else
                        begin
                            res[0]     = make_result(KIND_DROP, '0, '0);
                            phase_next = PH_IGNORE;
                        end
                    end
                    else
                    begin
                        res[0]      = make_result(KIND_BYTE, rx_byte, '0);
                        xor_next    = xor_reg ^ rx_byte;
                        remain_next = remain_reg - LEN_W'(1);
                    end
                end
                PH_IGNORE:
                begin
                end
                default:
                begin
                    phase_next = (rx_byte == hdr_first) ? PH_HUNT2 : PH_HUNT1;
                end
            endcase
        end

        // Drop an open frame and return to header hunt when the burst ends
        if (burst_end)
        begin
            if (phase_next == PH_LENHI || phase_next == PH_LENLO || phase_next == PH_BODY)
            begin
                res[cnt[0]] = make_result(KIND_DROP, '0, '0);
                cnt         = cnt + 2'd1;
            end
            phase_next  = PH_HUNT1;
            remain_next = '0;
        end

        // Mark the final result of this request
        if (cnt == 2'd1)
            res[0].last = 1'b1;
        else if (cnt == 2'd2)
            res[1].last = 1'b1;

        push.cnt  = cnt;
        push.res0 = res[0];
        push.res1 = res[1];
    end

endmodule

/* rtl/xcfd_result_queue.sv */
// Four-entry result queue: takes up to two results a cycle, hands out one.
// Depends on xcfd_pkg.
module xcfd_result_queue
    import xcfd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_en,
    input  push_t   push,
    input  logic    pop,
    output logic    space_ok,
    output logic    out_valid,
    output result_t out_res
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    result_t          entry_reg [DEPTH];
    logic [PTR_W-1:0] wptr_reg, wptr_next;
    logic [PTR_W-1:0] rptr_reg, rptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic [1:0]       n_push;
    logic             do_pop;

    assign n_push    = push_en ? push.cnt : 2'd0;
    assign out_valid = (count_reg != '0);
    assign do_pop    = pop && out_valid;
    assign out_res   = entry_reg[rptr_reg];
    // Room for a full two-result request
    assign space_ok  = (count_reg <= (PTR_W+1)'(DEPTH - 2));

    // Advance pointers and occupancy
    always_comb
    begin
        wptr_next  = wptr_reg + PTR_W'(n_push);
        rptr_next  = rptr_reg + PTR_W'(do_pop);
        count_next = count_reg + (PTR_W+1)'(n_push) - (PTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    // Store incoming results
    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            entry_reg[wptr_reg] <= push.res0;
        if (n_push == 2'd2)
            entry_reg[wptr_reg + PTR_W'(1)] <= push.res1;
    end

endmodule

/* rtl/xor_checked_frame_deframer.sv */
// Length-prefixed frame deframer with XOR check. Each request on item is a
// received byte or a line-idle event; a burst ends at idle or after BURST_BYTES
// bytes. Frames are header_first, header_second, a 16-bit big-endian length L,
// L-1 payload bytes and an XOR check byte; bytes go out tentatively, then a
// commit (frame_length = L+3) or a drop. The block takes one request per cycle
// while item.ready is high, i.e. while the queue has room for two results; each
// request yields zero to two results, which leave through a four-entry queue at
// one per cycle while result.ready is high. Header registers must be written by
// the user through the APB port only while idle; the block does not enforce it.
// Depends on xcfd_pkg, xcfd_item_if, xcfd_result_if, xcfd_core, xcfd_result_queue.
module xor_checked_frame_deframer
    import xcfd_pkg::*;
#(
    parameter int BURST_BYTES = BURST_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    xcfd_item_if.sink         item,
    xcfd_result_if.source     result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic              [BYTE_W-1:0] hdr_first_reg;
    logic              [BYTE_W-1:0] hdr_second_reg;
    logic              cfg_wr;
    logic              reg_sel;
    logic              accept;
    logic              space_ok;
    push_t             push;
    result_t           out_res;

    // Configuration registers
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_first_reg  <= HDR_FIRST_RST;
            hdr_second_reg <= HDR_SECOND_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_HDR_FIRST:  hdr_first_reg  <= pwdata[BYTE_W-1:0];
                REG_HDR_SECOND: hdr_second_reg <= pwdata[BYTE_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_HDR_FIRST:  prdata = {24'd0, hdr_first_reg};
            REG_HDR_SECOND: prdata = {24'd0, hdr_second_reg};
            default:        prdata = '0;
        endcase
    end

    // Accept a request when the queue can hold its results
    assign item.ready = space_ok;
    assign accept     = item.valid && space_ok;

    xcfd_core #(
        .BURST_BYTES (BURST_BYTES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .op         (item.op),
        .rx_byte    (item.rx_byte),
        .hdr_first  (hdr_first_reg),
        .hdr_second (hdr_second_reg),
        .push       (push)
    );

    xcfd_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (accept),
        .push      (push),
        .pop       (result.ready),
        .space_ok  (space_ok),
        .out_valid (result.valid),
        .out_res   (out_res)
    );

    // Drive result payload
    assign result.kind         = out_res.kind;
    assign result.frame_byte   = out_res.frame_byte;
    assign result.frame_length = out_res.frame_length;
    assign result.last         = out_res.last;

    // Commit and drop always close out their request
    a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && (result.kind == KIND_COMMIT || result.kind == KIND_DROP)
        |-> result.last)
        else $error("commit or drop result not marked last");

    // A commit covers at least the header and length bytes
    a_commit_len: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.kind == KIND_COMMIT |-> result.frame_length >= 17'd4)
        else $error("commit with impossible frame length");

    // Verdict results carry no byte; tentative bytes carry no length
    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |->
        ((result.kind == KIND_BYTE) ? (result.frame_length == '0)
                                    : (result.frame_byte == '0)))
        else $error("result carries stray payload");

    // No result kind outside byte, commit and drop
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> result.kind != 2'd3)
        else $error("unused result kind");

endmodule
